// File: design/gradient_stop_color_ramp_assert.svh
// assertion helpers for the gradient stop color ramp
`ifndef GRADIENT_STOP_COLOR_RAMP_ASSERT_SVH
`define GRADIENT_STOP_COLOR_RAMP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GRC_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define GRC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/grc_pkg.sv
`default_nettype none

package grc_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned NumChan   = 4;
  localparam int unsigned OffW      = 16;
  localparam int unsigned PosW      = 8;
  localparam int unsigned SlotW     = 3;
  localparam int unsigned CntW      = 4;
  localparam int unsigned ScaledW   = PosW + OffW;
  localparam int unsigned EntryW    = OffW + NumChan * ChanW;
  localparam int unsigned InDataW   = 64;
  localparam int unsigned OutDataW  = NumChan * ChanW;
  localparam int unsigned QDepth    = 2;

  localparam logic [CntW-1:0]  CountReset = 4'd2;
  localparam logic [ChanW-1:0] ChanMax    = 8'd255;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_type_e;

  typedef logic [NumChan-1:0][ChanW-1:0] rgba_t;

  typedef struct packed {
    req_type_e             req_type;
    logic [PosW-1:0]       position;
    logic [SlotW-1:0]      slot;
    logic [OffW-1:0]       offset;
    rgba_t                 color;
  } grc_cmd_t;

  typedef struct packed {
    logic                  lane_start;
    logic [NumChan-1:0]    lanes_busy;
  } grc_status_t;

endpackage

`default_nettype wire

// File: design/gradient_stop_color_ramp.sv
// gradient stop color ramp
// requests arrive on the s_axis channel: tuser picks a stop write or a ramp
// sample, tdata carries the position or the stop fields. a stop write fills
// one table entry and produces no response; a sample returns one RGBA8 color
// on m_axis, linearly interpolated between the two stops around the position
// and saturated to 0..255.
// the cfg channel sets stop_count (always ready); write it only while idle.
// a stop write retires in the back end as it leaves the queue. a sample
// leaves the queue, then the search reads and compares one segment per visit
// (segment index + 1 visits), fetches the first stop, forms the fraction and
// starts the channel units (serial 8-bit divide); the color is registered
// once all four have finished. the next request starts the cycle after; the
// stop table read port and the single back-end state machine set this.
// a two-entry request queue lets the front keep taking requests while the
// back end works or waits on a stalled m_axis; the output register holds
// the color until taken, and a stall backs up into the queue and s_axis.
// reset empties the queue and the output and sets stop_count to 2; stop
// contents are undefined until written.
`default_nettype none

`include "gradient_stop_color_ramp_assert.svh"

module gradient_stop_color_ramp #(
  parameter int unsigned MAX_STOPS      = 8,
  parameter int unsigned RAMP_POSITIONS = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration: stop_count
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [grc_pkg::CntW-1:0]       cfg_data_i,
  // requests
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // position[7:0], stop_slot[10:8], stop_offset[26:11], stop_red[34:27],
  // stop_green[42:35], stop_blue[50:43], stop_alpha[58:51], zero fill above
  input  wire logic [grc_pkg::InDataW-1:0]    s_axis_tdata_i,
  // req_type[0]
  input  wire logic [0:0]                     s_axis_tuser_i,
  // responses
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic [grc_pkg::OutDataW-1:0]        m_axis_tdata_o
);

  import grc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_STOPS);

  logic [CntW-1:0]   stop_count_q;
  grc_cmd_t          in_cmd;
  grc_cmd_t          q_cmd;
  logic              q_valid, q_pop;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;
  rgba_t             out_color;
  grc_status_t       status;

  // stop_count register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= CountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      stop_count_q <= cfg_data_i;
    end
  end

  // unpack the request fields
  assign in_cmd.req_type = req_type_e'(s_axis_tuser_i[0]);
  assign in_cmd.position = s_axis_tdata_i[7:0];
  assign in_cmd.slot     = s_axis_tdata_i[10:8];
  assign in_cmd.offset   = s_axis_tdata_i[26:11];
  assign in_cmd.color    = s_axis_tdata_i[58:27];

  // front: classify and queue requests
  grc_front #(
    .MAX_STOPS(MAX_STOPS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_cmd_i   (in_cmd),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_cmd_o   (q_cmd)
  );

  // stop table
  grc_ram #(
    .WIDTH(EntryW),
    .DEPTH(MAX_STOPS)
  ) u_stops (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // back: table writes, segment search and interpolation
  grc_back #(
    .MAX_STOPS      (MAX_STOPS),
    .RAMP_POSITIONS (RAMP_POSITIONS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stop_count_i (stop_count_q),
    .q_valid_i    (q_valid),
    .q_cmd_i      (q_cmd),
    .q_pop_o      (q_pop),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_color_o  (out_color),
    .status_o     (status)
  );

  assign m_axis_tdata_o = out_color;

  // table writes only happen between samples
  `GRC_ASSERT_IMPL(a_write_lanes_idle, clk_i, rst_ni, ram_we,
                   (status.lanes_busy == '0), "stop write during interpolation")
  // a new response only appears once every channel unit has finished
  `GRC_ASSERT_IMPL(a_resp_lanes_done, clk_i, rst_ni, $rose(m_axis_tvalid_o),
                   (status.lanes_busy == '0), "response before channel units done")
  // all channel units start together
  `GRC_ASSERT_NEXT(a_lanes_start, clk_i, rst_ni, status.lane_start,
                   (&status.lanes_busy), "channel unit failed to start")

endmodule

`default_nettype wire

// File: design/grc_ram.sv
`default_nettype none

module grc_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/grc_front.sv
`default_nettype none

module grc_front #(
  parameter int unsigned MAX_STOPS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  output logic                   s_ready_o,
  input  wire grc_pkg::grc_cmd_t s_cmd_i,
  output logic                   q_valid_o,
  input  wire logic              q_pop_i,
  output grc_pkg::grc_cmd_t      q_cmd_o
);

  import grc_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  grc_cmd_t              buf_q [QDepth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]         cnt_q;
  logic                  keep, push, pop;

  // writes to slots past the table are dropped here
  assign keep = (s_cmd_i.req_type == REQ_SAMPLE) ||
                (int'(s_cmd_i.slot) < int'(MAX_STOPS));

  assign s_ready_o = (cnt_q != (PtrW+1)'(QDepth));
  assign q_valid_o = (cnt_q != '0);
  assign q_cmd_o   = buf_q[rd_ptr_q];

  assign push = s_valid_i && s_ready_o && keep;
  assign pop  = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= s_cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: design/grc_lane.sv
`default_nettype none

module grc_lane #(
  parameter int unsigned PW = 24,
  parameter int unsigned NW = 25
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [7:0]           c0_i,
  input  wire logic [7:0]           c1_i,
  input  wire logic signed [NW-1:0] num_i,
  input  wire logic [PW-1:0]        den_i,
  input  wire logic                 den_zero_i,
  output logic                      busy_o,
  output logic [7:0]                res_o
);

  import grc_pkg::*;

  localparam int unsigned XW = NW + 10;
  localparam int unsigned RW = XW - 1;

  typedef enum logic [1:0] {
    L_IDLE,
    L_ADD,
    L_DIV
  } lane_state_e;

  lane_state_e             state_q;
  logic [PW+7:0]           ta_q;
  logic signed [NW+8:0]    tb_q;
  logic [PW-1:0]           den_q;
  logic                    dz_q;
  logic [7:0]              c1_q;
  logic [RW-1:0]           rem_q;
  logic [2:0]              bit_q;

  logic signed [8:0]       dc;
  logic signed [XW-1:0]    x;
  logic [RW-1:0]           den_sat;
  logic [RW-1:0]           den_sh;

  assign dc      = $signed({1'b0, c1_i}) - $signed({1'b0, c0_i});
  assign x       = $signed(XW'(ta_q)) + XW'(tb_q);
  assign den_sat = RW'(den_q) << 8;
  assign den_sh  = RW'(den_q) << bit_q;
  assign busy_o  = (state_q != L_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      ta_q    <= '0;
      tb_q    <= '0;
      den_q   <= '0;
      dz_q    <= 1'b0;
      c1_q    <= '0;
      rem_q   <= '0;
      bit_q   <= '0;
      res_o   <= '0;
    end else begin
      unique case (state_q)
        L_IDLE: begin
          if (start_i) begin
            // c0*den + (c1-c0)*num, both terms registered in the same cycle
            ta_q    <= (PW+8)'(c0_i) * (PW+8)'(den_i);
            tb_q    <= (NW+9)'(dc) * (NW+9)'(num_i);
            den_q   <= den_i;
            dz_q    <= den_zero_i;
            c1_q    <= c1_i;
            state_q <= L_ADD;
          end
        end
        L_ADD: begin
          if (dz_q) begin
            res_o   <= c1_q;
            state_q <= L_IDLE;
          end else if (x[XW-1]) begin
            res_o   <= '0;
            state_q <= L_IDLE;
          end else if (x[RW-1:0] >= den_sat) begin
            res_o   <= ChanMax;
            state_q <= L_IDLE;
          end else begin
            rem_q   <= x[RW-1:0];
            bit_q   <= 3'd7;
            res_o   <= '0;
            state_q <= L_DIV;
          end
        end
        L_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (rem_q >= den_sh) begin
            rem_q        <= rem_q - den_sh;
            res_o[bit_q] <= 1'b1;
          end
          if (bit_q == '0) begin
            state_q <= L_IDLE;
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/grc_back.sv
`default_nettype none

module grc_back #(
  parameter int unsigned MAX_STOPS      = 8,
  parameter int unsigned RAMP_POSITIONS = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [grc_pkg::CntW-1:0]      stop_count_i,
  input  wire logic                          q_valid_i,
  input  wire grc_pkg::grc_cmd_t             q_cmd_i,
  output logic                               q_pop_o,
  output logic                               ram_we_o,
  output logic [$clog2(MAX_STOPS)-1:0]       ram_waddr_o,
  output logic [grc_pkg::EntryW-1:0]         ram_wdata_o,
  output logic [$clog2(MAX_STOPS)-1:0]       ram_raddr_o,
  input  wire logic [grc_pkg::EntryW-1:0]    ram_rdata_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output grc_pkg::rgba_t                     out_color_o,
  output grc_pkg::grc_status_t               status_o
);

  import grc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_STOPS);
  localparam int unsigned DW = $clog2(RAMP_POSITIONS);
  localparam int unsigned PW = OffW + DW;
  localparam int unsigned MW = (PW > ScaledW) ? PW : ScaledW;
  localparam int unsigned NW = MW + 1;
  localparam logic [DW-1:0] DScale = DW'(RAMP_POSITIONS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_CMP,
    S_RD0,
    S_MUL0,
    S_NUM,
    S_START,
    S_WAIT
  } back_state_e;

  back_state_e            state_q;
  logic [AW-1:0]          idx_q;
  logic [ScaledW-1:0]     pscaled_q;
  logic [PW-1:0]          prod0_q, prod1_q;
  rgba_t                  c0_q, c1_q;
  logic signed [NW-1:0]   num_q;
  logic [PW-1:0]          den_q;
  logic                   dz_q;

  logic [AW-1:0]          last_idx;
  logic [OffW-1:0]        rd_off;
  rgba_t                  rd_color;
  logic [PW-1:0]          prod;
  logic                   advance;
  logic [PW:0]            den_diff;
  logic signed [NW-1:0]   num_fwd, num_rev;
  logic                   lane_start;
  logic [NumChan-1:0]     lanes_busy;
  rgba_t                  lane_res;
  logic                   finish;

  // last usable segment start, stop count clamped to 2..MAX_STOPS
  always_comb begin
    if (stop_count_i < CntW'(2)) begin
      last_idx = '0;
    end else if (int'(stop_count_i) > int'(MAX_STOPS)) begin
      last_idx = AW'(MAX_STOPS - 2);
    end else begin
      last_idx = AW'(stop_count_i - CntW'(2));
    end
  end

  assign rd_off   = ram_rdata_i[OffW-1:0];
  assign rd_color = ram_rdata_i[EntryW-1:OffW];
  assign prod     = PW'(rd_off) * PW'(DScale);

  assign advance  = (idx_q < last_idx) && (MW'(pscaled_q) > MW'(prod1_q));

  assign den_diff = {1'b0, prod1_q} - {1'b0, prod0_q};
  assign num_fwd  = $signed({1'b0, MW'(pscaled_q)}) - $signed({1'b0, MW'(prod0_q)});
  assign num_rev  = $signed({1'b0, MW'(prod0_q)}) - $signed({1'b0, MW'(pscaled_q)});

  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign ram_we_o    = q_pop_o && (q_cmd_i.req_type == REQ_WRITE);
  assign ram_waddr_o = AW'(q_cmd_i.slot);
  assign ram_wdata_o = {q_cmd_i.color, q_cmd_i.offset};
  assign ram_raddr_o = (state_q == S_RD0) ? idx_q : AW'(idx_q + 1'b1);

  assign lane_start  = (state_q == S_START);
  assign finish      = (state_q == S_WAIT) && (lanes_busy == '0) &&
                       (!out_valid_o || out_ready_i);

  assign status_o.lane_start = lane_start;
  assign status_o.lanes_busy = lanes_busy;

  for (genvar k = 0; k < NumChan; k++) begin : g_lane
    grc_lane #(
      .PW(PW),
      .NW(NW)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (lane_start),
      .c0_i       (c0_q[k]),
      .c1_i       (c1_q[k]),
      .num_i      (num_q),
      .den_i      (den_q),
      .den_zero_i (dz_q),
      .busy_o     (lanes_busy[k]),
      .res_o      (lane_res[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      pscaled_q   <= '0;
      prod0_q     <= '0;
      prod1_q     <= '0;
      c0_q        <= '0;
      c1_q        <= '0;
      num_q       <= '0;
      den_q       <= '0;
      dz_q        <= 1'b0;
      out_valid_o <= 1'b0;
      out_color_o <= '0;
    end else begin
      // a finishing sample reloads the output in the same cycle
      if (out_valid_o && out_ready_i && !finish) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i && (q_cmd_i.req_type == REQ_SAMPLE)) begin
            // position * 65535 as shift and subtract
            pscaled_q <= {q_cmd_i.position, OffW'(0)} - ScaledW'(q_cmd_i.position);
            idx_q     <= '0;
            state_q   <= S_RD;
          end
        end
        S_RD: state_q <= S_MUL;
        S_MUL: begin
          prod1_q <= prod;
          c1_q    <= rd_color;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (advance) begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_RD;
          end else begin
            state_q <= S_RD0;
          end
        end
        S_RD0: state_q <= S_MUL0;
        S_MUL0: begin
          prod0_q <= prod;
          c0_q    <= rd_color;
          state_q <= S_NUM;
        end
        S_NUM: begin
          // fold the sign of the segment width into the numerator
          if (den_diff[PW]) begin
            den_q <= PW'(prod0_q - prod1_q);
            num_q <= num_rev;
          end else begin
            den_q <= den_diff[PW-1:0];
            num_q <= num_fwd;
          end
          dz_q    <= (prod0_q == prod1_q);
          state_q <= S_START;
        end
        S_START: state_q <= S_WAIT;
        S_WAIT: begin
          if (finish) begin
            out_valid_o <= 1'b1;
            out_color_o <= lane_res;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
